// ===== sv/stack_machine_execute_unit_assert.svh =====
// Assertion macros shared by the execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smx assertion failed");
`define SMX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smx assertion failed");
`else
`define SMX_ASSERT_NOW(lbl, ante, cons)
`define SMX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/smx_pkg.sv =====
package smx_pkg;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int HEAP_DEPTH_DEF  = 64;
	localparam int SP_SLACK        = 4;

	localparam logic [4:0] OP_ADD      = 5'd0;
	localparam logic [4:0] OP_SUB      = 5'd1;
	localparam logic [4:0] OP_MUL      = 5'd2;
	localparam logic [4:0] OP_DIV      = 5'd3;
	localparam logic [4:0] OP_MOD      = 5'd4;
	localparam logic [4:0] OP_EQ       = 5'd5;
	localparam logic [4:0] OP_LT       = 5'd6;
	localparam logic [4:0] OP_LE       = 5'd7;
	localparam logic [4:0] OP_NOT      = 5'd8;
	localparam logic [4:0] OP_PUSH     = 5'd9;
	localparam logic [4:0] OP_COPY     = 5'd10;
	localparam logic [4:0] OP_POP      = 5'd11;
	localparam logic [4:0] OP_SELECT   = 5'd12;
	localparam logic [4:0] OP_HLOAD    = 5'd13;
	localparam logic [4:0] OP_HSTORE   = 5'd14;
	localparam logic [4:0] OP_ASSERT   = 5'd15;
	localparam logic [4:0] OP_JTRUE    = 5'd16;
	localparam logic [4:0] OP_JFALSE   = 5'd17;
	localparam logic [4:0] OP_JUMP     = 5'd18;
	localparam logic [4:0] OP_ASSERTSP = 5'd19;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_OVER    = 4'd1;
	localparam logic [3:0] ST_UNDER   = 4'd2;
	localparam logic [3:0] ST_ZERODIV = 4'd3;
	localparam logic [3:0] ST_ASSERT  = 4'd4;
	localparam logic [3:0] ST_SPMIS   = 4'd5;
	localparam logic [3:0] ST_BADREL  = 4'd6;
	localparam logic [3:0] ST_ILLEGAL = 4'd7;
	localparam logic [3:0] ST_HEAP    = 4'd8;
	localparam logic [3:0] ST_NEGJMP  = 4'd9;

	localparam logic [1:0] AK_MUL = 2'd0;
	localparam logic [1:0] AK_DIV = 2'd1;
	localparam logic [1:0] AK_MOD = 2'd2;

	typedef struct packed {
		logic [4:0]         action;
		logic signed [31:0] immediate;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic signed [63:0] top_value;
		logic [7:0]         stack_depth;
		logic [3:0]         status;
		logic               done_res;
	} out_item_t;

	typedef struct packed {
		logic [4:0]         action;
		logic signed [31:0] immediate;
		logic [1:0]         need;
		logic               pc_step2;
		logic               illegal;
	} dec_t;

	typedef struct packed {
		logic       start;
		logic [1:0] kind;
	} arith_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== sv/smx_arith.sv =====
module smx_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  smx_pkg::arith_ctl_t ctl,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output logic [63:0]         res
);

	logic        busy_q, done_q, negq_q, negr_q;
	logic [1:0]  kind_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q, b_q, prod_q, acc_q, quo_q, rem_q, den_q, res_q;
	logic [64:0] trial;
	logic        fits, last;
	logic [31:0] mx, my;
	logic [63:0] mp;

	// one bit of restoring division a cycle
	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign fits  = !trial[64];
	assign last  = (kind_q == smx_pkg::AK_MUL) ? (cnt_q == 7'd3) : (cnt_q == 7'd64);

	// shared 32x32 multiplier for the three low partial products
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
			2'd1:    begin mx = a_q[31:0];  my = b_q[63:32]; end
			default: begin mx = a_q[63:32]; my = b_q[31:0];  end
		endcase
	end
	assign mp = 64'(mx) * 64'(my);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			kind_q <= ctl.kind;
			a_q    <= a;
			b_q    <= b;
			den_q  <= b[63] ? (64'd0 - b) : b;
			quo_q  <= a[63] ? (64'd0 - a) : a;
			rem_q  <= '0;
			negq_q <= a[63] ^ b[63];
			negr_q <= a[63];
		end else if (busy_q) begin
			if (kind_q == smx_pkg::AK_MUL) begin
				unique case (cnt_q[1:0])
					2'd0: prod_q <= mp;
					2'd1: begin
						acc_q  <= prod_q;
						prod_q <= mp;
					end
					2'd2: begin
						acc_q  <= acc_q + {prod_q[31:0], 32'd0};
						prod_q <= mp;
					end
					default: res_q <= acc_q + {prod_q[31:0], 32'd0};
				endcase
			end else if (cnt_q == 7'd64) begin
				if (kind_q == smx_pkg::AK_DIV)
					res_q <= negq_q ? (64'd0 - quo_q) : quo_q;
				else
					res_q <= negr_q ? (64'd0 - rem_q) : rem_q;
			end else begin
				rem_q <= fits ? trial[63:0] : {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], fits};
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== sv/smx_queue.sv =====
module smx_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  smx_pkg::dec_t    push_data,
	input  logic             pop,
	output smx_pkg::dec_t    pop_data,
	output smx_pkg::q_stat_t stat
);

	smx_pkg::dec_t ent_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          do_push, do_pop;

	assign do_push = push && (cnt_q != 2'd2);
	assign do_pop  = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wp_q] <= push_data;
	end

	assign pop_data   = ent_q[rp_q];
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

endmodule

// ===== sv/smx_front.sv =====
module smx_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  smx_pkg::in_item_t in_item,
	input  smx_pkg::q_stat_t  q_stat,
	input  logic              clearing,
	output logic              push,
	output smx_pkg::dec_t     push_data
);

	// hold the input while the queue is full or the heap is being cleared
	assign in_stall = q_stat.full || clearing;
	assign push     = in_valid && !in_stall;

	always_comb begin
		push_data.action    = in_item.action;
		push_data.immediate = in_item.immediate;
		push_data.illegal   = 1'b0;
		push_data.need      = 2'd0;
		push_data.pc_step2  = 1'b1;
		unique case (in_item.action)
			smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV,
			smx_pkg::OP_MOD, smx_pkg::OP_EQ, smx_pkg::OP_LT, smx_pkg::OP_LE: begin
				push_data.need     = 2'd2;
				push_data.pc_step2 = 1'b0;
			end
			smx_pkg::OP_NOT, smx_pkg::OP_POP: begin
				push_data.need     = 2'd1;
				push_data.pc_step2 = 1'b0;
			end
			smx_pkg::OP_SELECT: begin
				push_data.need     = 2'd3;
				push_data.pc_step2 = 1'b0;
			end
			smx_pkg::OP_HSTORE, smx_pkg::OP_ASSERT, smx_pkg::OP_JTRUE,
			smx_pkg::OP_JFALSE: push_data.need = 2'd1;
			smx_pkg::OP_PUSH, smx_pkg::OP_COPY, smx_pkg::OP_HLOAD, smx_pkg::OP_JUMP,
			smx_pkg::OP_ASSERTSP: push_data.need = 2'd0;
			default: push_data.illegal = 1'b1;
		endcase
	end

endmodule

// ===== sv/smx_back.sv =====
module smx_back #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int HEAP_DEPTH  = smx_pkg::HEAP_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  smx_pkg::q_stat_t   q_stat,
	input  smx_pkg::dec_t      q_data,
	output logic               q_pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_stall,
	output smx_pkg::out_item_t out_item
);

	localparam int SPW = $clog2(STACK_DEPTH);
	localparam int HAW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD1   = 3'd2;
	localparam logic [2:0] S_RD2   = 3'd3;
	localparam logic [2:0] S_EXEC  = 3'd4;
	localparam logic [2:0] S_ARITH = 3'd5;
	localparam logic [2:0] S_WB    = 3'd6;

	logic [2:0]         state_q;
	logic [HAW-1:0]     clr_q;
	logic [SPW-1:0]     sp_q;
	logic [15:0]        pc_q, len_q;
	logic [63:0]        tos_q, opa_q, rd_q, hrd_q;
	smx_pkg::dec_t      inst_q;
	logic               out_valid_q;
	smx_pkg::out_item_t out_q;

	logic [63:0]        stk_mem [STACK_DEPTH];
	logic [63:0]        heap_mem [HEAP_DEPTH];

	logic [4:0]         op;
	logic signed [31:0] simm;
	logic [63:0]        imm64, alu_r, ar_res, wval, ntos;
	logic [32:0]        neg33;
	logic [SPW-1:0]     rd_addr, nsp;
	logic [HAW-1:0]     haddr;
	logic [16:0]        pinc;
	logic [15:0]        pc_seq, npc;
	logic signed [33:0] tgt;
	logic               under, hbad, ovf, taken, done_now;
	logic [3:0]         st;
	logic               stk_we, hwe, use_ar, grow, ar_done;
	logic [1:0]         ar_kind;
	logic               out_free, commit, rpt, load_out;
	smx_pkg::arith_ctl_t ar_ctl;

	assign op    = inst_q.action;
	assign simm  = inst_q.immediate;
	assign imm64 = 64'(simm);
	assign neg33 = 33'd0 - {simm[31], simm};
	assign haddr = simm[HAW-1:0];

	assign under    = sp_q < SPW'(inst_q.need);
	assign hbad     = simm[31] || ($unsigned(simm) >= 32'(HEAP_DEPTH));
	assign ovf      = ({1'b0, sp_q} + (SPW+1)'(1)) >= (SPW+1)'(STACK_DEPTH - smx_pkg::SP_SLACK);
	assign taken    = (op == smx_pkg::OP_JUMP) || ((tos_q != 64'd0) == (op == smx_pkg::OP_JTRUE));
	assign done_now = pc_q >= len_q;

	assign pinc   = {1'b0, pc_q} + (inst_q.pc_step2 ? 17'd2 : 17'd1);
	assign pc_seq = pinc[16] ? 16'hFFFF : pinc[15:0];
	assign tgt    = $signed({18'd0, pc_q}) + 34'(simm);

	assign rd_addr = (state_q == S_RD1) ?
		((op == smx_pkg::OP_COPY) ? (sp_q - neg33[SPW-1:0]) : (sp_q - SPW'(1))) :
		(sp_q - SPW'(2));

	always_comb begin
		unique case (op)
			smx_pkg::OP_ADD:    alu_r = opa_q + tos_q;
			smx_pkg::OP_SUB:    alu_r = opa_q - tos_q;
			smx_pkg::OP_EQ:     alu_r = 64'(opa_q == tos_q);
			smx_pkg::OP_LT:     alu_r = 64'($signed(opa_q) < $signed(tos_q));
			smx_pkg::OP_LE:     alu_r = 64'($signed(opa_q) <= $signed(tos_q));
			smx_pkg::OP_NOT:    alu_r = 64'(tos_q == 64'd0);
			smx_pkg::OP_SELECT: alu_r = (tos_q != 64'd0) ? rd_q : opa_q;
			default:            alu_r = 64'd0;
		endcase
	end

	// outcome of the instruction held in inst_q
	always_comb begin
		st      = smx_pkg::ST_OK;
		nsp     = sp_q;
		npc     = pc_seq;
		stk_we  = 1'b0;
		hwe     = 1'b0;
		use_ar  = 1'b0;
		ar_kind = smx_pkg::AK_MUL;
		grow    = 1'b0;
		wval    = alu_r;
		ntos    = tos_q;
		if (inst_q.illegal) begin
			st = smx_pkg::ST_ILLEGAL;
		end else if (under) begin
			st = smx_pkg::ST_UNDER;
		end else begin
			unique case (op)
				smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_EQ, smx_pkg::OP_LT,
				smx_pkg::OP_LE: begin
					nsp    = sp_q - SPW'(1);
					stk_we = 1'b1;
					ntos   = alu_r;
				end
				smx_pkg::OP_MUL, smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
					if (op != smx_pkg::OP_MUL && tos_q == 64'd0) begin
						st = smx_pkg::ST_ZERODIV;
					end else begin
						use_ar  = 1'b1;
						ar_kind = (op == smx_pkg::OP_MUL) ? smx_pkg::AK_MUL :
							(op == smx_pkg::OP_DIV) ? smx_pkg::AK_DIV : smx_pkg::AK_MOD;
						nsp     = sp_q - SPW'(1);
						stk_we  = 1'b1;
						wval    = ar_res;
						ntos    = ar_res;
					end
				end
				smx_pkg::OP_NOT: begin
					stk_we = 1'b1;
					ntos   = alu_r;
				end
				smx_pkg::OP_SELECT: begin
					nsp    = sp_q - SPW'(2);
					stk_we = 1'b1;
					ntos   = alu_r;
				end
				smx_pkg::OP_PUSH: begin
					grow = 1'b1;
					wval = imm64;
				end
				smx_pkg::OP_COPY: begin
					if (!simm[31] && simm != 32'sd0) st = smx_pkg::ST_BADREL;
					else if (neg33 >= 33'(sp_q)) st = smx_pkg::ST_UNDER;
					else begin
						grow = 1'b1;
						wval = opa_q;
					end
				end
				smx_pkg::OP_HLOAD: begin
					if (hbad) st = smx_pkg::ST_HEAP;
					else begin
						grow = 1'b1;
						wval = hrd_q;
					end
				end
				smx_pkg::OP_HSTORE: begin
					if (hbad) st = smx_pkg::ST_HEAP;
					else begin
						hwe  = 1'b1;
						nsp  = sp_q - SPW'(1);
						ntos = opa_q;
					end
				end
				smx_pkg::OP_POP: begin
					nsp  = sp_q - SPW'(1);
					ntos = opa_q;
				end
				smx_pkg::OP_ASSERT: begin
					if (tos_q == 64'd0) st = smx_pkg::ST_ASSERT;
					else begin
						nsp  = sp_q - SPW'(1);
						ntos = opa_q;
					end
				end
				smx_pkg::OP_JTRUE, smx_pkg::OP_JFALSE, smx_pkg::OP_JUMP: begin
					if (taken) begin
						if (tgt[33]) st = smx_pkg::ST_NEGJMP;
						else npc = (|tgt[32:16]) ? 16'hFFFF : tgt[15:0];
					end
				end
				smx_pkg::OP_ASSERTSP: begin
					if (33'(sp_q) != 33'(simm)) st = smx_pkg::ST_SPMIS;
				end
				default: ;
			endcase
			if (grow) begin
				nsp    = sp_q + SPW'(1);
				stk_we = 1'b1;
				ntos   = wval;
				if (ovf) st = smx_pkg::ST_OVER;
			end
		end
		// drop every state change on a fault
		if (st != smx_pkg::ST_OK) begin
			nsp    = sp_q;
			npc    = pc_q;
			stk_we = 1'b0;
			hwe    = 1'b0;
			use_ar = 1'b0;
			ntos   = tos_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign rpt      = (state_q == S_EXEC) && done_now;
	assign commit   = ((state_q == S_EXEC) && !done_now && !use_ar) || (state_q == S_WB);
	assign load_out = (rpt || commit) && out_free;
	assign q_pop    = (state_q == S_IDLE) && !q_stat.empty;
	assign clearing = (state_q == S_CLEAR);

	assign ar_ctl.start = (state_q == S_EXEC) && !done_now && use_ar;
	assign ar_ctl.kind  = ar_kind;

	smx_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ar_ctl),
		.a      (opa_q),
		.b      (tos_q),
		.done   (ar_done),
		.res    (ar_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			pc_q        <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) len_q <= cfg_wdata;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (load_out && commit) begin
				sp_q <= nsp;
				pc_q <= npc;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + HAW'(1);
					if (clr_q == HAW'(HEAP_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE:  if (!q_stat.empty) state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_EXEC;
				S_EXEC: begin
					if (ar_ctl.start) state_q <= S_ARITH;
					else if (load_out) state_q <= S_IDLE;
				end
				S_ARITH: if (ar_done) state_q <= S_WB;
				S_WB:    if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) inst_q <= q_data;
		if (state_q == S_RD2) opa_q <= rd_q;
		if (load_out && commit) tos_q <= ntos;
		if (load_out) begin
			if (rpt) begin
				out_q.next_pc     <= pc_q;
				out_q.top_value   <= (sp_q == '0) ? 64'sd0 : $signed(tos_q);
				out_q.stack_depth <= 8'(sp_q);
				out_q.status      <= smx_pkg::ST_OK;
				out_q.done_res    <= 1'b1;
			end else begin
				out_q.next_pc     <= npc;
				out_q.top_value   <= (nsp == '0) ? 64'sd0 : $signed(ntos);
				out_q.stack_depth <= 8'(nsp);
				out_q.status      <= st;
				out_q.done_res    <= npc >= len_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && commit && stk_we) stk_mem[nsp] <= wval;
		rd_q <= stk_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) heap_mem[clr_q] <= 64'd0;
		else if (load_out && commit && hwe) heap_mem[haddr] <= tos_q;
		hrd_q <= heap_mem[haddr];
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/stack_machine_execute_unit.sv =====
// Stack-machine execute unit: runs one instruction (opcode plus signed 32-bit
// immediate) per transfer on in_item and returns one result per instruction on
// out_item. After reset the heap is cleared to zero, one word a cycle, so the
// input stalls through the clearing pass before the first transfer. A
// two-entry queue parts the decoding front from the executing back. The back
// walks a sequencer over the stack memory: take, read second operand, read
// third operand, execute; mul then forms three 32x32 partial products on one
// multiplier, div and mod find one quotient bit per cycle, and both write back.
// The top of stack lives in a register, so the stack memory is read at one
// address a cycle. The user must write code_length through cfg_we/cfg_wdata
// only while the unit is idle; the unit does not enforce it. Once the pc
// reaches code_length every further instruction is ignored, reported as done.
`include "stack_machine_execute_unit_assert.svh"

module stack_machine_execute_unit #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int HEAP_DEPTH  = smx_pkg::HEAP_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  smx_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output smx_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);

	smx_pkg::q_stat_t q_stat;
	smx_pkg::dec_t    push_data, pop_data;
	logic             q_push, q_pop, clearing;

	// front: classify the opcode and push into the queue
	smx_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.q_stat    (q_stat),
		.clearing  (clearing),
		.push      (q_push),
		.push_data (push_data)
	);

	smx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// back: execute against stack, heap, sp and pc; drive the output register
	smx_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.HEAP_DEPTH  (HEAP_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// hold the input for the whole clearing pass
	`SMX_ASSERT_NOW(a_clear_stalls, clearing, in_stall)
	// never push into a full queue
	`SMX_ASSERT_NOW(a_no_overfill, q_push, !q_stat.full)
	// a transfer into an empty queue is visible next cycle
	`SMX_ASSERT_NEXT(a_push_lands, q_push && q_stat.empty, !q_stat.empty)
	// a fault never changes pc, so it cannot report done
	`SMX_ASSERT_NOW(a_fault_not_done, out_valid && (out_item.status != smx_pkg::ST_OK),
		!out_item.done_res)

endmodule

// ===== test/tb.sv =====
module tb;
	import smx_pkg::*;

	localparam int STK_N       = 256;
	localparam int HEAP_N      = 64;
	localparam int CYCLE_LIMIT = 3000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	stack_machine_execute_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Period 4: two time units high, two low
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow machine state, advanced at every accepted instruction
	logic [63:0] stk_mem [STK_N];
	logic [63:0] heap_mem [HEAP_N];
	int          stk_ptr;
	int          prog_ctr;
	int          code_len;

	out_item_t   result_q [$];
	int          errors = 0;
	int          accepted = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	// Payload tags for the transfer now on offer: a typed-in result or none
	bit          cur_fixed = 1'b0;
	out_item_t   cur_res = '0;

	typedef struct {
		logic [4:0] op;
		int         imm;
		bit         fixed;
		out_item_t  res;
	} row_t;

	row_t        rows [$];

	// Run one instruction on the shadow state and return the report
	function automatic out_item_t execute_instr(in_item_t it);
		logic [4:0]  op;
		longint      simm;
		logic [63:0] imm64, a, b, r, v, top;
		int          need, nsp, npc, st;
		longint      target;
		out_item_t   o;
		op = it.action;
		simm = longint'(it.immediate);
		imm64 = 64'(simm);
		a = '0; b = '0; r = '0; v = '0;
		need = 0; nsp = stk_ptr; npc = prog_ctr; st = ST_OK;
		if (prog_ctr < code_len) begin
			if (op > OP_ASSERTSP) begin
				st = ST_ILLEGAL;
			end else begin
				if (op <= OP_LE) need = 2;
				else if (op == OP_NOT || op == OP_POP || op == OP_HSTORE ||
					op == OP_ASSERT || op == OP_JTRUE || op == OP_JFALSE) need = 1;
				else if (op == OP_SELECT) need = 3;
				if (stk_ptr < need) st = ST_UNDER;
			end
			if (st == ST_OK) begin
				top = stk_mem[stk_ptr];
				if (need >= 2) begin
					a = stk_mem[stk_ptr - 1];
					b = top;
				end
				if (op <= OP_NOT || op == OP_POP || op == OP_SELECT) npc = prog_ctr + 1;
				else npc = prog_ctr + 2;
				if (npc > 65535) npc = 65535;
				case (op)
					OP_ADD: begin r = a + b; nsp = stk_ptr - 1; end
					OP_SUB: begin r = a - b; nsp = stk_ptr - 1; end
					OP_MUL: begin r = a * b; nsp = stk_ptr - 1; end
					OP_DIV, OP_MOD: begin
						if (b == '0) begin
							st = ST_ZERODIV;
						end else begin
							// minus one divisor: negate (wrapping) or zero remainder
							if (b == '1) r = (op == OP_DIV) ? -a : '0;
							else if (op == OP_DIV) r = $signed(a) / $signed(b);
							else r = $signed(a) % $signed(b);
							nsp = stk_ptr - 1;
						end
					end
					OP_EQ: begin r = 64'(a == b); nsp = stk_ptr - 1; end
					OP_LT: begin r = 64'($signed(a) < $signed(b)); nsp = stk_ptr - 1; end
					OP_LE: begin r = 64'($signed(a) <= $signed(b)); nsp = stk_ptr - 1; end
					OP_NOT: r = 64'(top == '0);
					OP_PUSH: begin v = imm64; nsp = stk_ptr + 1; end
					OP_COPY: begin
						if (simm > 0) st = ST_BADREL;
						else if (-simm >= stk_ptr) st = ST_UNDER;
						else begin
							v = stk_mem[stk_ptr - int'(-simm)];
							nsp = stk_ptr + 1;
						end
					end
					OP_POP: nsp = stk_ptr - 1;
					OP_SELECT: begin
						r = (top != '0) ? stk_mem[stk_ptr - 2] : stk_mem[stk_ptr - 1];
						nsp = stk_ptr - 2;
					end
					OP_HLOAD, OP_HSTORE: begin
						if (simm < 0 || simm >= HEAP_N) st = ST_HEAP;
						else if (op == OP_HLOAD) begin
							v = heap_mem[simm];
							nsp = stk_ptr + 1;
						end else nsp = stk_ptr - 1;
					end
					OP_ASSERT: begin
						if (top == '0) st = ST_ASSERT;
						else nsp = stk_ptr - 1;
					end
					OP_JTRUE, OP_JFALSE, OP_JUMP: begin
						if (op == OP_JUMP || ((top != '0) == (op == OP_JTRUE))) begin
							target = longint'(prog_ctr) + simm;
							if (target < 0) st = ST_NEGJMP;
							else npc = (target > 65535) ? 65535 : int'(target);
						end
					end
					default: if (longint'(stk_ptr) != simm) st = ST_SPMIS;
				endcase
				if (st == ST_OK && nsp >= STK_N - SP_SLACK) st = ST_OVER;
				if (st == ST_OK) begin
					if (op <= OP_NOT || op == OP_SELECT) stk_mem[nsp] = r;
					else if (op == OP_PUSH || op == OP_COPY || op == OP_HLOAD) stk_mem[nsp] = v;
					else if (op == OP_HSTORE) heap_mem[simm] = top;
					stk_ptr = nsp;
					prog_ctr = npc;
				end
			end
		end
		o.next_pc     = 16'(prog_ctr);
		o.top_value   = (stk_ptr != 0) ? stk_mem[stk_ptr] : '0;
		o.stack_depth = 8'(stk_ptr);
		o.status      = 4'(st);
		o.done_res    = (prog_ctr >= code_len);
		return o;
	endfunction

	// Predict on every accepted input transfer
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			out_item_t p;
			p = execute_instr(in_item);
			result_q.push_back(cur_fixed ? cur_res : p);
			accepted++;
		end
	end

	// Check every accepted output transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			out_item_t e;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, out_item);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (out_item.next_pc !== e.next_pc)
					$display("%0t: next_pc expected %0d actual %0d", $time, e.next_pc, out_item.next_pc);
				if (out_item.top_value !== e.top_value)
					$display("%0t: top_value expected %0d actual %0d", $time, e.top_value,
						out_item.top_value);
				if (out_item.stack_depth !== e.stack_depth)
					$display("%0t: stack_depth expected %0d actual %0d", $time, e.stack_depth,
						out_item.stack_depth);
				if (out_item.status !== e.status)
					$display("%0t: status expected %0d actual %0d", $time, e.status, out_item.status);
				if (out_item.done_res !== e.done_res)
					$display("%0t: done_res expected %0d actual %0d", $time, e.done_res,
						out_item.done_res);
				if (out_item !== e) errors++;
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off to back the unit up, none when quiet
	initial begin
		int hold;
		bit long_done;
		hold = 0;
		long_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_done && accepted >= 400) begin
				long_done = 1'b1;
				hold = 600;
			end
			if (hold > 0) begin
				hold--;
				out_stall = 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 19) - 1;
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Offer one instruction, hold it until the transfer, then maybe drop valid for a burst
	task automatic send_instr(logic [4:0] op, int imm, bit fixed, out_item_t res);
		in_item.action    = op;
		in_item.immediate = imm;
		cur_fixed         = fixed;
		cur_res           = res;
		in_valid          = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	// Write code_length once every expected result has come back
	task automatic write_code_len(int value);
		in_valid = 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = 16'(value);
		@(negedge clk);
		cfg_we   = 1'b0;
		code_len = value;
	endtask

	// Random instruction; fill mode leans on pushes, drain mode on consumers
	task automatic send_random(bit fill);
		logic [4:0] op;
		int         imm, sel;
		sel = $urandom_range(0, 99);
		if (sel < 4) op = 5'($urandom_range(20, 31));
		else if (sel < 50) begin
			if (fill) op = (sel < 35) ? OP_PUSH : ((sel < 43) ? OP_COPY : OP_HLOAD);
			else op = (sel < 30) ? 5'($urandom_range(0, 8)) : ((sel < 40) ? OP_POP : OP_SELECT);
		end else op = 5'($urandom_range(0, 19));
		sel = $urandom_range(0, 9);
		case (op)
			OP_PUSH: imm = (sel < 6) ? int'($urandom) : $urandom_range(0, 6) - 3;
			OP_COPY: imm = (sel == 0) ? int'($urandom) : -int'($urandom_range(0, stk_ptr));
			OP_HLOAD, OP_HSTORE: imm = (sel == 0) ? int'($urandom) : $urandom_range(0, HEAP_N - 1);
			OP_JTRUE, OP_JFALSE, OP_JUMP:
				// large offsets only negative, so the pc never pins at the top
				imm = (sel == 0) ? int'($urandom | 32'h8000_0000) : $urandom_range(0, 40) - 20;
			OP_ASSERTSP: imm = (sel < 7) ? stk_ptr + $urandom_range(0, 2) - 1 : int'($urandom);
			default: imm = int'($urandom);
		endcase
		send_instr(op, imm, 1'b0, '0);
	endtask

	task automatic add_row(logic [4:0] op, int imm, bit fixed, out_item_t res);
		row_t r;
		r.op = op; r.imm = imm; r.fixed = fixed; r.res = res;
		rows.push_back(r);
	endtask

	initial begin
		bit fill;
		for (int i = 0; i < STK_N; i++) stk_mem[i] = '0;
		for (int i = 0; i < HEAP_N; i++) heap_mem[i] = '0;
		stk_ptr = 0; prog_ctr = 0; code_len = 0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Code length zero: every instruction is ignored and reported done
		write_code_len(0);
		send_instr(OP_PUSH, 5, 1'b1, '{16'd0, 64'sd0, 8'd0, ST_OK, 1'b1});
		send_instr(OP_ADD, -1, 1'b0, '0);
		write_code_len(65535);

		add_row(OP_POP, 0, 1'b1, '{16'd0, 64'sd0, 8'd0, ST_UNDER, 1'b0});
		add_row(OP_PUSH, 32'h7fff_ffff, 1'b1, '{16'd2, 64'sd2147483647, 8'd1, ST_OK, 1'b0});
		add_row(OP_PUSH, 32'h8000_0000, 1'b1, '{16'd4, -64'sd2147483648, 8'd2, ST_OK, 1'b0});
		add_row(OP_ADD, 0, 1'b0, '0);
		add_row(OP_PUSH, 0, 1'b0, '0);
		add_row(OP_DIV, 0, 1'b1, '{16'd7, 64'sd0, 8'd2, ST_ZERODIV, 1'b0});
		add_row(OP_POP, 0, 1'b0, '0);
		// Build the most negative value: (-2^31)^2 * 2 wraps to -2^63
		add_row(OP_PUSH, 32'h8000_0000, 1'b0, '0);
		add_row(OP_COPY, 0, 1'b0, '0);
		add_row(OP_MUL, 0, 1'b0, '0);
		add_row(OP_PUSH, 2, 1'b0, '0);
		add_row(OP_MUL, 0, 1'b0, '0);
		add_row(OP_COPY, 0, 1'b0, '0);
		add_row(OP_PUSH, -1, 1'b0, '0);
		add_row(OP_DIV, 0, 1'b0, '0);
		add_row(OP_PUSH, -1, 1'b0, '0);
		add_row(OP_MOD, 0, 1'b0, '0);
		add_row(OP_COPY, 1, 1'b0, '0);
		add_row(OP_COPY, -200, 1'b0, '0);
		add_row(OP_HSTORE, 63, 1'b0, '0);
		add_row(OP_HLOAD, 63, 1'b0, '0);
		add_row(OP_HLOAD, 64, 1'b0, '0);
		add_row(OP_HLOAD, -1, 1'b0, '0);
		add_row(OP_HLOAD, 0, 1'b0, '0);
		add_row(OP_SUB, 0, 1'b0, '0);
		add_row(OP_PUSH, 7, 1'b0, '0);
		add_row(OP_EQ, 0, 1'b0, '0);
		add_row(OP_LT, 0, 1'b0, '0);
		add_row(OP_PUSH, -3, 1'b0, '0);
		add_row(OP_LE, 0, 1'b0, '0);
		add_row(OP_NOT, 0, 1'b0, '0);
		add_row(OP_SELECT, 0, 1'b0, '0);
		add_row(OP_PUSH, 0, 1'b0, '0);
		add_row(OP_ASSERT, 0, 1'b0, '0);
		add_row(OP_ASSERTSP, 99, 1'b0, '0);
		add_row(OP_JTRUE, 4, 1'b0, '0);
		add_row(OP_JFALSE, -2, 1'b0, '0);
		add_row(OP_JUMP, -100000, 1'b0, '0);
		add_row(5'd20, 0, 1'b0, '0);
		add_row(5'd31, -1, 1'b0, '0);
		foreach (rows[i]) send_instr(rows[i].op, rows[i].imm, rows[i].fixed, rows[i].res);

		fill = 1'b1;
		for (int n = 0; n < 800; n++) begin
			if ($urandom_range(0, 99) == 0) fill = !fill;
			send_random(fill);
		end
		// Short program: the pc runs past the end partway through this phase
		write_code_len(prog_ctr + 30);
		for (int n = 0; n < 300; n++) send_random($urandom_range(0, 1));
		write_code_len(65535);
		for (int n = 0; n < 850; n++) begin
			if (n == 550) quiet = 1'b1;
			if ($urandom_range(0, 99) == 0) fill = !fill;
			send_random(fill);
		end
		// Far jump pins the pc at its ceiling; the rest is reported done
		send_instr(OP_JUMP, 32'h7fff_ffff, 1'b0, '0);
		send_instr(OP_PUSH, 1, 1'b0, '0);
		send_instr(OP_POP, 0, 1'b0, '0);
		in_valid = 1'b0;

		while (result_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/smx_pkg.sv
sv/smx_arith.sv
sv/smx_queue.sv
sv/smx_front.sv
sv/smx_back.sv
sv/stack_machine_execute_unit.sv
test/tb.sv
